FILE: sv/dasd_pkg.sv
// ----------------------------------------------------------------------------
// dasd_pkg
// Types, constants, calendar helpers and microcode encodings shared by the
// date add/subtract days block.
// ----------------------------------------------------------------------------
package dasd_pkg;

  localparam int DAY_COUNT_BITS = 16;
  localparam int CNT_FIELD_BITS = 16;
  localparam int CNT_BITS = (DAY_COUNT_BITS < CNT_FIELD_BITS) ? DAY_COUNT_BITS : CNT_FIELD_BITS;
  localparam int DAY_W = CNT_BITS + 2;

  localparam logic [11:0] YEAR_MIN  = 12'd1900;
  localparam logic [11:0] YEAR_2100 = 12'd2100;
  localparam logic [11:0] YEAR_MAX  = 12'd2200;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_START = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_INIT   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_BRANCH = 3'd2;
  localparam logic [STEP_W-1:0] STEP_ADD    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SUB    = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DONE   = 3'd5;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_INIT,
    OP_ADD,
    OP_SUB
  } op_e;

  typedef enum logic [2:0] {
    C_IN_VALID,
    C_BAD,
    C_SUB,
    C_ADD_END,
    C_SUB_END,
    C_OUT_READY
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              stay;
    logic              in_ready;
    logic              out_valid;
  } ctrl_t;

  typedef struct packed {
    logic bad;
    logic sub;
    logic add_end;
    logic sub_end;
  } dp_stat_t;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [11:0] start_year;
    logic [15:0] day_count;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [11:0] result_year;
    logic [1:0]  status;
  } out_word_t;

  // Century rule reduced to the only centuries inside 1900..2200.
  function automatic logic is_leap(logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != YEAR_MIN) && (y != YEAR_2100) && (y != YEAR_MAX);
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_FEB:                  len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: sv/dasd_seq.sv
// ----------------------------------------------------------------------------
// dasd_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module dasd_seq import dasd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output ctrl_t    ctrl_o
);

  logic [STEP_W-1:0] pc_q, pc_d;
  ctrl_t             ctrl;
  logic              hit;

  always_comb begin
    case (pc_q)
      STEP_IDLE:   ctrl = '{OP_NOP,  C_IN_VALID,  STEP_INIT,   1'b1, 1'b1, 1'b0};
      STEP_INIT:   ctrl = '{OP_INIT, C_BAD,       STEP_DONE,   1'b0, 1'b0, 1'b0};
      STEP_BRANCH: ctrl = '{OP_NOP,  C_SUB,       STEP_SUB,    1'b0, 1'b0, 1'b0};
      STEP_ADD:    ctrl = '{OP_ADD,  C_ADD_END,   STEP_DONE,   1'b1, 1'b0, 1'b0};
      STEP_SUB:    ctrl = '{OP_SUB,  C_SUB_END,   STEP_DONE,   1'b1, 1'b0, 1'b0};
      STEP_DONE:   ctrl = '{OP_NOP,  C_OUT_READY, STEP_IDLE,   1'b1, 1'b0, 1'b1};
      default:     ctrl = '{OP_NOP,  C_OUT_READY, STEP_IDLE,   1'b0, 1'b0, 1'b0};
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      C_IN_VALID:  hit = in_valid_i;
      C_BAD:       hit = stat_i.bad;
      C_SUB:       hit = stat_i.sub;
      C_ADD_END:   hit = stat_i.add_end;
      C_SUB_END:   hit = stat_i.sub_end;
      C_OUT_READY: hit = out_ready_i;
      default:     hit = 1'b0;
    endcase
  end

  always_comb begin
    if (hit) begin
      pc_d = ctrl.target;
    end else if (ctrl.stay) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

FILE: sv/dasd_dp.sv
// ----------------------------------------------------------------------------
// dasd_dp
// Date datapath: start check, signed day accumulator and one-month
// normalization step in either direction.
// ----------------------------------------------------------------------------
module dasd_dp import dasd_pkg::*; (
  input  logic      clk_i,
  input  ctrl_t     ctrl_i,
  input  logic      load_i,
  input  in_word_t  in_word_i,
  output dp_stat_t  stat_o,
  output out_word_t out_word_o
);

  logic                    sub_q;
  logic signed [DAY_W-1:0] day_q;
  logic [3:0]              mon_q;
  logic [11:0]             yr_q;
  logic [CNT_BITS-1:0]     cnt_q;
  logic [1:0]              status_q;

  logic                    start_bad;
  logic [4:0]              len_cur, len_dec;
  logic signed [DAY_W-1:0] len_cur_s, len_dec_s, cnt_s, day_one;
  logic                    add_more, sub_more, add_range, sub_range;
  logic [3:0]              mon_inc, mon_dec;
  logic [11:0]             yr_inc, yr_dec;

  assign day_one   = $signed(DAY_W'(1));
  assign len_cur   = month_len(mon_q, is_leap(yr_q));
  assign len_cur_s = $signed({{(DAY_W-5){1'b0}}, len_cur});
  assign cnt_s     = $signed({2'b00, cnt_q});

  assign start_bad = (yr_q < YEAR_MIN) || (yr_q > YEAR_MAX) || (mon_q < MONTH_JAN) ||
                     (mon_q > MONTH_DEC) || (day_q < day_one) || (day_q > len_cur_s);

  assign add_more  = day_q > len_cur_s;
  assign mon_inc   = (mon_q == MONTH_DEC) ? MONTH_JAN : mon_q + 4'd1;
  assign yr_inc    = (mon_q == MONTH_DEC) ? yr_q + 12'd1 : yr_q;
  assign add_range = (mon_q == MONTH_DEC) && (yr_q == YEAR_MAX);

  assign sub_more  = day_q < day_one;
  assign mon_dec   = (mon_q == MONTH_JAN) ? MONTH_DEC : mon_q - 4'd1;
  assign yr_dec    = (mon_q == MONTH_JAN) ? yr_q - 12'd1 : yr_q;
  assign sub_range = (mon_q == MONTH_JAN) && (yr_q == YEAR_MIN);
  assign len_dec   = month_len(mon_dec, is_leap(yr_dec));
  assign len_dec_s = $signed({{(DAY_W-5){1'b0}}, len_dec});

  assign stat_o.bad     = start_bad;
  assign stat_o.sub     = sub_q;
  assign stat_o.add_end = !add_more || add_range;
  assign stat_o.sub_end = !sub_more || sub_range;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sub_q <= in_word_i.req_type;
      day_q <= $signed({{(DAY_W-5){1'b0}}, in_word_i.start_day});
      mon_q <= in_word_i.start_month;
      yr_q  <= in_word_i.start_year;
      cnt_q <= in_word_i.day_count[CNT_BITS-1:0];
    end else begin
      case (ctrl_i.op)
        OP_INIT: begin
          status_q <= start_bad ? ST_BAD_START : ST_OK;
          day_q    <= sub_q ? day_q - cnt_s : day_q + cnt_s;
        end
        OP_ADD: begin
          if (add_more) begin
            if (add_range) begin
              status_q <= ST_RANGE;
            end else begin
              day_q <= day_q - len_cur_s;
              mon_q <= mon_inc;
              yr_q  <= yr_inc;
            end
          end
        end
        OP_SUB: begin
          if (sub_more) begin
            if (sub_range) begin
              status_q <= ST_RANGE;
            end else begin
              day_q <= day_q + len_dec_s;
              mon_q <= mon_dec;
              yr_q  <= yr_dec;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (status_q == ST_OK) begin
      out_word_o = '{day_q[4:0], mon_q, yr_q, ST_OK};
    end else begin
      out_word_o = '{5'd0, 4'd0, 12'd0, status_q};
    end
  end

endmodule

FILE: sv/date_add_subtract_days.sv
// ----------------------------------------------------------------------------
// date_add_subtract_days
// Gregorian date plus or minus a day count, normalized one month per cycle.
// ----------------------------------------------------------------------------
// One word at a time: after a start word is taken, the block checks the start
// date, chooses the direction, then crosses the month boundaries one by one
// until the day fits its month, and holds the result until it is taken. An
// invalid start date skips the direction choice and the month steps and goes
// straight to the result.
// A new word is taken in the cycle after the result is accepted.
module date_add_subtract_days import dasd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  ctrl_t    ctrl;
  dp_stat_t stat;
  logic     load;

  assign load = in_valid_i && ctrl.in_ready;

  dasd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  dasd_dp u_dp (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .load_i     (load),
    .in_word_i  (in_data_i),
    .stat_o     (stat),
    .out_word_o (out_data_o)
  );

  assign in_ready_o  = ctrl.in_ready;
  assign out_valid_o = ctrl.out_valid;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output sides open together");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("block not busy after accepting a word");

  a_idle_after_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> in_ready_o && !out_valid_o)
    else $error("block not idle after delivering a word");

  a_ok_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_OK |->
      out_data_o.result_month >= MONTH_JAN && out_data_o.result_month <= MONTH_DEC &&
      out_data_o.result_year >= YEAR_MIN && out_data_o.result_year <= YEAR_MAX &&
      out_data_o.result_day != 5'd0)
    else $error("ok result is not a valid date");

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for date_add_subtract_days. A table of directed words
// covers date extremes, leap days, bad start dates and out-of-range results,
// then random words follow, mostly valid dates with random counts. Each
// result is compared with its table entry or a behavioral date calculator,
// under random idling on both handshakes, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top import dasd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 6;
  localparam int N_RANDOM       = 250;
  localparam int TAIL_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_AT        = 40;
  localparam int HOLD_CYCLES    = 600;
  localparam int WAIT_MAX       = 17;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_SUB = 1'b1;

  typedef struct packed {
    logic      typed;
    in_word_t  stim;
    out_word_t want;
  } dir_row_t;

  localparam out_word_t ERR_BAD_START = '{5'd0, 4'd0, 12'd0, ST_BAD_START};
  localparam out_word_t ERR_RANGE     = '{5'd0, 4'd0, 12'd0, ST_RANGE};
  localparam out_word_t PREDICTED     = '0;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{1'b1, '{REQ_ADD, 5'd1,  4'd1,  12'd1900, 16'd0},     '{5'd1, 4'd1, 12'd1900, ST_OK}},
    '{1'b1, '{REQ_SUB, 5'd31, 4'd12, 12'd2200, 16'd0},     '{5'd31, 4'd12, 12'd2200, ST_OK}},
    '{1'b1, '{REQ_ADD, 5'd31, 4'd12, 12'd2200, 16'd1},     ERR_RANGE},
    '{1'b1, '{REQ_SUB, 5'd1,  4'd1,  12'd1900, 16'd1},     ERR_RANGE},
    '{1'b1, '{REQ_ADD, 5'd29, 4'd2,  12'd2000, 16'd0},     '{5'd29, 4'd2, 12'd2000, ST_OK}},
    '{1'b1, '{REQ_ADD, 5'd29, 4'd2,  12'd1900, 16'd5},     ERR_BAD_START},
    '{1'b1, '{REQ_SUB, 5'd29, 4'd2,  12'd2100, 16'd5},     ERR_BAD_START},
    '{1'b1, '{REQ_ADD, 5'd29, 4'd2,  12'd2200, 16'd5},     ERR_BAD_START},
    '{1'b1, '{REQ_ADD, 5'd0,  4'd1,  12'd1950, 16'd3},     ERR_BAD_START},
    '{1'b1, '{REQ_SUB, 5'd31, 4'd4,  12'd2000, 16'd3},     ERR_BAD_START},
    '{1'b1, '{REQ_ADD, 5'd10, 4'd0,  12'd2000, 16'd3},     ERR_BAD_START},
    '{1'b1, '{REQ_SUB, 5'd1,  4'd13, 12'd2000, 16'd3},     ERR_BAD_START},
    '{1'b1, '{REQ_ADD, 5'd31, 4'd15, 12'd4095, 16'hFFFF},  ERR_BAD_START},
    '{1'b1, '{REQ_ADD, 5'd1,  4'd1,  12'd1899, 16'd3},     ERR_BAD_START},
    '{1'b1, '{REQ_SUB, 5'd1,  4'd1,  12'd2201, 16'd3},     ERR_BAD_START},
    '{1'b1, '{REQ_ADD, 5'd0,  4'd0,  12'd0,    16'd0},     ERR_BAD_START},
    '{1'b1, '{REQ_ADD, 5'd28, 4'd2,  12'd1900, 16'd1},     '{5'd1, 4'd3, 12'd1900, ST_OK}},
    '{1'b1, '{REQ_ADD, 5'd28, 4'd2,  12'd2000, 16'd1},     '{5'd29, 4'd2, 12'd2000, ST_OK}},
    '{1'b1, '{REQ_SUB, 5'd1,  4'd3,  12'd2100, 16'd1},     '{5'd28, 4'd2, 12'd2100, ST_OK}},
    '{1'b1, '{REQ_ADD, 5'd31, 4'd12, 12'd1999, 16'd1},     '{5'd1, 4'd1, 12'd2000, ST_OK}},
    '{1'b0, '{REQ_ADD, 5'd1,  4'd1,  12'd1900, 16'hFFFF},  PREDICTED},
    '{1'b0, '{REQ_SUB, 5'd31, 4'd12, 12'd2200, 16'hFFFF},  PREDICTED},
    '{1'b0, '{REQ_ADD, 5'd15, 4'd6,  12'd2150, 16'hFFFF},  PREDICTED},
    '{1'b0, '{REQ_SUB, 5'd1,  4'd1,  12'd1950, 16'hFFFF},  PREDICTED},
    '{1'b0, '{REQ_ADD, 5'd31, 4'd1,  12'd2024, 16'd30},    PREDICTED},
    '{1'b0, '{REQ_SUB, 5'd1,  4'd1,  12'd2000, 16'd366},   PREDICTED}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_word_t out_data_o;

  out_word_t expected_dates [$];
  int        mismatch_cnt = 0;
  int        tx_calm = 0;
  int        rx_calm = 0;
  int        results_taken = 0;
  int        quiet_cycles = 0;

  date_add_subtract_days u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic bit leap_year(int y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int days_in_month(int m, int y);
    int len;
    case (m)
      2: begin
        len = leap_year(y) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        len = 30;
      end
      default: begin
        len = 31;
      end
    endcase
    return len;
  endfunction

  function automatic out_word_t predict_date(in_word_t w);
    out_word_t r;
    int d;
    int m;
    int y;
    int cnt;
    r = '0;
    m = int'(w.start_month);
    y = int'(w.start_year);
    d = int'(w.start_day);
    cnt = int'(w.day_count) & ((1 << CNT_BITS) - 1);
    if (y < int'(YEAR_MIN) || y > int'(YEAR_MAX) || m < 1 || m > 12 ||
        d < 1 || d > days_in_month(m, y)) begin
      r.status = ST_BAD_START;
      return r;
    end
    if (w.req_type == REQ_ADD) begin
      d = d + cnt;
      while (d > days_in_month(m, y)) begin
        d = d - days_in_month(m, y);
        m++;
        if (m > 12) begin
          m = 1;
          y++;
          if (y > int'(YEAR_MAX)) begin
            r.status = ST_RANGE;
            return r;
          end
        end
      end
    end else begin
      d = d - cnt;
      while (d < 1) begin
        m--;
        if (m < 1) begin
          m = 12;
          y--;
          if (y < int'(YEAR_MIN)) begin
            r.status = ST_RANGE;
            return r;
          end
        end
        d = d + days_in_month(m, y);
      end
    end
    r.result_day   = 5'(d);
    r.result_month = 4'(m);
    r.result_year  = 12'(y);
    r.status       = ST_OK;
    return r;
  endfunction

  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(5, 20);
    return $urandom_range(0, WAIT_MAX);
  endfunction

  function automatic in_word_t random_word();
    in_word_t   w;
    logic [63:0] raw;
    int         pick;
    raw = {$urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 12) return w;
    if (pick < 24) begin
      w.start_year = ($urandom_range(0, 1) == 1) ? 12'($urandom_range(1900, 1906))
                                                   : 12'($urandom_range(2194, 2200));
    end else begin
      w.start_year = 12'($urandom_range(1900, 2200));
    end
    w.start_month = 4'($urandom_range(1, 12));
    w.start_day = 5'($urandom_range(1, days_in_month(int'(w.start_month),
                                                     int'(w.start_year))));
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      w.day_count = 16'($urandom_range(0, 400));
    end else if (pick < 90) begin
      w.day_count = 16'($urandom_range(0, 4000));
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("tb_top: mismatch on %s: got %0d, want %0d", what, got, want);
    mismatch_cnt++;
  endtask

  task automatic send_word(in_word_t w, out_word_t want);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_dates.push_back(want);
  endtask

  initial begin
    in_word_t  w;
    out_word_t want;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < DIR_ROWS; i++) begin
      want = DIR_TAB[i].typed ? DIR_TAB[i].want : predict_date(DIR_TAB[i].stim);
      send_word(DIR_TAB[i].stim, want);
    end
    repeat (N_RANDOM) begin
      w = random_word();
      send_word(w, predict_date(w));
    end
    in_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    int        stall;
    out_word_t got;
    out_word_t want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(rx_calm);
      if (results_taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got = out_data_o;
      results_taken++;
      if (expected_dates.size() == 0) begin
        report_mismatch("unexpected word, status", int'(got.status), -1);
      end else begin
        want = expected_dates.pop_front();
        if (got.result_day !== want.result_day)
          report_mismatch("result_day", int'(got.result_day), int'(want.result_day));
        if (got.result_month !== want.result_month)
          report_mismatch("result_month", int'(got.result_month), int'(want.result_month));
        if (got.result_year !== want.result_year)
          report_mismatch("result_year", int'(got.result_year), int'(want.result_year));
        if (got.status !== want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: watchdog expired, no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
